[sv/csb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types and constants for the clipped alpha sprite blitter.
// ----------------------------------------------------------------------------

package csb_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam int SIZE_W     = 11;
  localparam int POS_W      = 12;
  localparam int CNT_W      = 10;
  localparam int COORD_W    = 13;
  localparam int ADDR_W     = 20;

  localparam logic [SIZE_W-1:0] SIZE_MIN = 11'd1;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 11'd1024;
  localparam logic [SIZE_W-1:0] CLIP_MAX = 11'd1024;
  localparam logic [7:0]        ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0]        ALPHA_CLEAR  = 8'd0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SPRITE_WIDTH  = 3'd0,
    REG_SPRITE_HEIGHT = 3'd1,
    REG_POS_X         = 3'd2,
    REG_POS_Y         = 3'd3,
    REG_CLIP_LEFT     = 3'd4,
    REG_CLIP_RIGHT    = 3'd5,
    REG_CLIP_TOP      = 3'd6,
    REG_CLIP_BOTTOM   = 3'd7
  } cfg_reg_t;

  // Sprite sizes are held already limited to 1..1024.
  typedef struct packed {
    logic        [SIZE_W-1:0] sprite_width;
    logic        [SIZE_W-1:0] sprite_height;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic        [SIZE_W-1:0] clip_left;
    logic        [SIZE_W-1:0] clip_right;
    logic        [SIZE_W-1:0] clip_top;
    logic        [SIZE_W-1:0] clip_bottom;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  // One placed texel between the walker and the pixel stage.
  typedef struct packed {
    pixel_t                    src;
    pixel_t                    dst;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } texel_t;

endpackage

[sv/csb_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_cfg
// Configuration register file; sprite sizes are limited when written.
// ----------------------------------------------------------------------------

module csb_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [csb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [csb_pkg::CFG_DATA_W-1:0] cfg_data,
  output csb_pkg::cfg_t                  cfg
);

  csb_pkg::cfg_t                     cfg_r;
  csb_pkg::cfg_t                     cfg_nxt;
  logic [csb_pkg::SIZE_W-1:0]        v11;
  logic [csb_pkg::SIZE_W-1:0]        size_lim;

  assign v11 = cfg_data[csb_pkg::SIZE_W-1:0];

  always_comb begin
    if (v11 == '0) begin
      size_lim = csb_pkg::SIZE_MIN;
    end else if (v11 > csb_pkg::SIZE_MAX) begin
      size_lim = csb_pkg::SIZE_MAX;
    end else begin
      size_lim = v11;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (csb_pkg::cfg_reg_t'(cfg_addr))
        csb_pkg::REG_SPRITE_WIDTH:  cfg_nxt.sprite_width  = size_lim;
        csb_pkg::REG_SPRITE_HEIGHT: cfg_nxt.sprite_height = size_lim;
        csb_pkg::REG_POS_X:         cfg_nxt.pos_x         = $signed(cfg_data);
        csb_pkg::REG_POS_Y:         cfg_nxt.pos_y         = $signed(cfg_data);
        csb_pkg::REG_CLIP_LEFT:     cfg_nxt.clip_left     = v11;
        csb_pkg::REG_CLIP_RIGHT:    cfg_nxt.clip_right    = v11;
        csb_pkg::REG_CLIP_TOP:      cfg_nxt.clip_top      = v11;
        csb_pkg::REG_CLIP_BOTTOM:   cfg_nxt.clip_bottom   = v11;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sprite_width  <= csb_pkg::SIZE_MIN;
      cfg_r.sprite_height <= csb_pkg::SIZE_MIN;
      cfg_r.pos_x         <= '0;
      cfg_r.pos_y         <= '0;
      cfg_r.clip_left     <= '0;
      cfg_r.clip_right    <= csb_pkg::CLIP_MAX;
      cfg_r.clip_top      <= '0;
      cfg_r.clip_bottom   <= csb_pkg::CLIP_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[sv/csb_walk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_walk
// Input stage: raster counters place each accepted texel on screen.
// ----------------------------------------------------------------------------

module csb_walk (
  input  logic            clk,
  input  logic            rst_n,
  input  csb_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  csb_pkg::pixel_t in_src,
  input  csb_pkg::pixel_t in_dst,
  input  logic            pix_ready,
  output logic            s1_valid,
  output csb_pkg::texel_t s1
);

  logic [csb_pkg::CNT_W-1:0]  col_r, col_nxt;
  logic [csb_pkg::CNT_W-1:0]  row_r, row_nxt;
  logic                       s1_valid_r, s1_valid_nxt;
  csb_pkg::texel_t            s1_r, s1_nxt;
  logic [csb_pkg::SIZE_W-1:0] col_inc, row_inc;
  logic                       end_row, end_all, accept;

  assign in_stall = s1_valid_r && !pix_ready;
  assign accept   = in_valid && !in_stall;

  assign col_inc = {1'b0, col_r} + 11'd1;
  assign row_inc = {1'b0, row_r} + 11'd1;
  assign end_row = col_inc >= cfg.sprite_width;
  assign end_all = end_row && (row_inc >= cfg.sprite_height);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (end_all) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (end_row) begin
        col_nxt = '0;
        row_nxt = row_inc[csb_pkg::CNT_W-1:0];
      end else begin
        col_nxt = col_inc[csb_pkg::CNT_W-1:0];
      end
    end
  end

  // The slot refills whenever it is empty or its item moves on this cycle.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!s1_valid_r || pix_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_comb begin
    s1_nxt      = s1_r;
    if (accept) begin
      s1_nxt.src  = in_src;
      s1_nxt.dst  = in_dst;
      s1_nxt.x    = {cfg.pos_x[csb_pkg::POS_W-1], cfg.pos_x} + $signed({3'b000, col_r});
      s1_nxt.y    = {cfg.pos_y[csb_pkg::POS_W-1], cfg.pos_y} + $signed({3'b000, row_r});
      s1_nxt.last = end_all;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

[sv/csb_pix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_pix
// Result stage: clip test, address, alpha blend and the output register.
// ----------------------------------------------------------------------------

module csb_pix #(
  parameter int SCREEN_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  csb_pkg::cfg_t               cfg,
  input  logic                        s1_valid,
  input  csb_pkg::texel_t             s1,
  output logic                        pix_ready,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_write,
  output logic [csb_pkg::ADDR_W-1:0]  out_addr,
  output csb_pkg::pixel_t             out_pix,
  output logic                        out_last
);

  localparam int SW_BITS = $clog2(SCREEN_WIDTH + 1);
  localparam int PROD_W  = csb_pkg::COORD_W + SW_BITS + 1;
  localparam logic signed [SW_BITS:0] SW_S = (SW_BITS + 1)'(SCREEN_WIDTH);

  // dst + floor(a * (src - dst) / 256), kept to eight bits.
  function automatic logic [7:0] blend(input logic [7:0] s, input logic [7:0] d,
                                       input logic [7:0] a);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [17:0] shifted;
    diff    = $signed({1'b0, s}) - $signed({1'b0, d});
    prod    = $signed({1'b0, a}) * diff;
    shifted = prod >>> 8;
    return d + shifted[7:0];
  endfunction

  logic                              valid_r, valid_nxt;
  logic                              write_r, write_nxt;
  logic [csb_pkg::ADDR_W-1:0]        addr_r, addr_nxt;
  csb_pkg::pixel_t                   pix_r, pix_nxt;
  logic                              last_r, last_nxt;
  logic                              take, kept, write;
  logic signed [PROD_W-1:0]          row_base;
  logic signed [csb_pkg::COORD_W-1:0] cl, cr, ct, cb;

  assign pix_ready = !valid_r || !out_stall;
  assign take      = s1_valid && pix_ready;

  assign cl = $signed({2'b00, cfg.clip_left});
  assign cr = $signed({2'b00, cfg.clip_right});
  assign ct = $signed({2'b00, cfg.clip_top});
  assign cb = $signed({2'b00, cfg.clip_bottom});

  assign kept  = (s1.x >= cl) && (s1.x < cr) && (s1.y >= ct) && (s1.y < cb);
  assign write = kept && (s1.src.alpha != csb_pkg::ALPHA_CLEAR);

  // Off-screen points simply wrap in the twenty-bit address.
  assign row_base = s1.y * SW_S;

  always_comb begin
    valid_nxt = valid_r;
    if (pix_ready) begin
      valid_nxt = s1_valid;
    end
  end

  always_comb begin
    write_nxt = write_r;
    addr_nxt  = addr_r;
    pix_nxt   = pix_r;
    last_nxt  = last_r;
    if (take) begin
      write_nxt = write;
      addr_nxt  = csb_pkg::ADDR_W'(row_base) + csb_pkg::ADDR_W'(s1.x);
      last_nxt  = s1.last;
      if (write && s1.src.alpha == csb_pkg::ALPHA_OPAQUE) begin
        pix_nxt = s1.src;
      end else if (write) begin
        pix_nxt.red   = blend(s1.src.red,   s1.dst.red,   s1.src.alpha);
        pix_nxt.green = blend(s1.src.green, s1.dst.green, s1.src.alpha);
        pix_nxt.blue  = blend(s1.src.blue,  s1.dst.blue,  s1.src.alpha);
        pix_nxt.alpha = s1.dst.alpha;
      end else begin
        pix_nxt = s1.dst;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    write_r <= write_nxt;
    addr_r  <= addr_nxt;
    pix_r   <= pix_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_write = write_r;
  assign out_addr  = addr_r;
  assign out_pix   = pix_r;
  assign out_last  = last_r;

endmodule

[sv/clipped_alpha_sprite_blit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_alpha_sprite_blit
// Places raster-order sprite texels on screen, clips them and alpha blends
// each one over the destination pixel it is paired with.
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   in       in_valid / in_stall  in_src_*, in_dst_* (8 bits each)
//   out      out_valid/out_stall  out_write_pixel, out_pixel_address, out_red,
//                                 out_green, out_blue, out_alpha, out_last_texel
//   cfg      cfg_we               cfg_addr (3 bits), cfg_data (12 bits)
//
// One item per cycle sustained while out_stall stays low; each item passes
// from input to result through the placement register and the result register.
// The blend and address multiplies sit between those two registers.
// Reset clears the raster counters and both stage valids and sets the config defaults.
// in_stall rises only when both stages hold items and out_stall is high.

module clipped_alpha_sprite_blit #(
  parameter int SCREEN_WIDTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [csb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [csb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_src_red,
  input  logic [7:0]                     in_src_green,
  input  logic [7:0]                     in_src_blue,
  input  logic [7:0]                     in_src_alpha,
  input  logic [7:0]                     in_dst_red,
  input  logic [7:0]                     in_dst_green,
  input  logic [7:0]                     in_dst_blue,
  input  logic [7:0]                     in_dst_alpha,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_write_pixel,
  output logic [csb_pkg::ADDR_W-1:0]     out_pixel_address,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic [7:0]                     out_alpha,
  output logic                           out_last_texel
);

  csb_pkg::cfg_t   cfg;
  csb_pkg::pixel_t in_src, in_dst, out_pix;
  csb_pkg::texel_t s1;
  logic            s1_valid, pix_ready;

  assign in_src = '{red: in_src_red, green: in_src_green, blue: in_src_blue,
                    alpha: in_src_alpha};
  assign in_dst = '{red: in_dst_red, green: in_dst_green, blue: in_dst_blue,
                    alpha: in_dst_alpha};

  csb_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  csb_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_src    (in_src),
    .in_dst    (in_dst),
    .pix_ready (pix_ready),
    .s1_valid  (s1_valid),
    .s1        (s1)
  );

  csb_pix #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_pix (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .pix_ready (pix_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_write (out_write_pixel),
    .out_addr  (out_pixel_address),
    .out_pix   (out_pix),
    .out_last  (out_last_texel)
  );

  assign out_red   = out_pix.red;
  assign out_green = out_pix.green;
  assign out_blue  = out_pix.blue;
  assign out_alpha = out_pix.alpha;

endmodule

[sv/csb_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_chk
// Port-level checks for the sprite blitter, bound to the top level.
// ----------------------------------------------------------------------------

module csb_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [csb_pkg::ADDR_W-1:0] out_pixel_address,
  input logic [7:0]                 out_red,
  input logic                       out_write_pixel
);

  // The input is held back only when the result stage is itself blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a blocked result");

  // After an accepted item has passed the placement and result registers, out_valid is high.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##2 out_valid)
    else $error("accepted item did not reach the output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_pixel_address) && $stable(out_red) &&
       $stable(out_write_pixel)))
    else $error("stalled result changed");

endmodule

bind clipped_alpha_sprite_blit csb_chk u_csb_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_pixel_address (out_pixel_address),
  .out_red           (out_red),
  .out_write_pixel   (out_write_pixel)
);
